@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// prop must hold at every rising clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ sv/pwsc_pkg.sv @@
// Package: widths, register map, types and sequencer states of the servo compare core.
`timescale 1ns / 1ps
package pwsc_pkg;

  localparam int TICK_WIDTH = 16;   // tick counter width, 8..32
  localparam int REG_W      = 16;   // config register and output field width
  localparam int CMP_W      = (TICK_WIDTH + 1 > REG_W) ? TICK_WIDTH + 1 : REG_W;
  localparam int DIV_STEPS  = REG_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [2:0] REG_WRAP_LIMIT = 3'd0;
  localparam logic [2:0] REG_IN_LOW     = 3'd1;
  localparam logic [2:0] REG_IN_HIGH    = 3'd2;
  localparam logic [2:0] REG_OUT_LOW    = 3'd3;
  localparam logic [2:0] REG_OUT_HIGH   = 3'd4;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_PIN  = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] wrap_limit;
    logic [REG_W-1:0] in_low;
    logic [REG_W-1:0] in_high;
    logic [REG_W-1:0] out_low;
    logic [REG_W-1:0] out_high;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ sv/pwsc_regs.sv @@
// APB register file holding the wrap limit and the input/output ranges.
`timescale 1ns / 1ps
module pwsc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pwsc_pkg::ADDR_W-1:0]     paddr,
  input  logic [pwsc_pkg::DATA_W-1:0]     pwdata,
  output logic [pwsc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output pwsc_pkg::cfg_t                  cfg
);

  logic                          wr_en;
  logic [2:0]                    idx;
  logic [pwsc_pkg::REG_W-1:0]    wval;
  logic [pwsc_pkg::REG_W-1:0]    rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];
  assign wval   = pwdata[pwsc_pkg::REG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_limit <= pwsc_pkg::REG_W'(60000);
      cfg.in_low     <= pwsc_pkg::REG_W'(50);
      cfg.in_high    <= pwsc_pkg::REG_W'(90);
      cfg.out_low    <= pwsc_pkg::REG_W'(1000);
      cfg.out_high   <= pwsc_pkg::REG_W'(5000);
    end else if (wr_en) begin
      case (idx)
        pwsc_pkg::REG_WRAP_LIMIT: cfg.wrap_limit <= wval;
        pwsc_pkg::REG_IN_LOW:     cfg.in_low     <= wval;
        pwsc_pkg::REG_IN_HIGH:    cfg.in_high    <= wval;
        pwsc_pkg::REG_OUT_LOW:    cfg.out_low    <= wval;
        pwsc_pkg::REG_OUT_HIGH:   cfg.out_high   <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pwsc_pkg::REG_WRAP_LIMIT: rval = cfg.wrap_limit;
      pwsc_pkg::REG_IN_LOW:     rval = cfg.in_low;
      pwsc_pkg::REG_IN_HIGH:    rval = cfg.in_high;
      pwsc_pkg::REG_OUT_LOW:    rval = cfg.out_low;
      pwsc_pkg::REG_OUT_HIGH:   rval = cfg.out_high;
      default:                  rval = '0;
    endcase
  end

  assign prdata = pwsc_pkg::DATA_W'(rval);

endmodule

@@ sv/pwsc_meas.sv @@
// Tick counter, rise capture and absolute pulse width measurement.
`timescale 1ns / 1ps
module pwsc_meas (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                req_type,
  input  logic                                pin_level,
  input  logic [pwsc_pkg::REG_W-1:0]          wrap_limit,
  output logic [pwsc_pkg::TICK_WIDTH-1:0]     measured_width
);

  logic [pwsc_pkg::TICK_WIDTH-1:0] tick_count;
  logic [pwsc_pkg::TICK_WIDTH-1:0] rise_tick;
  logic [pwsc_pkg::TICK_WIDTH:0]   tick_inc;
  logic [pwsc_pkg::TICK_WIDTH-1:0] tick_count_next;
  logic [pwsc_pkg::TICK_WIDTH-1:0] width_abs;

  assign tick_inc = {1'b0, tick_count} + 1'b1;

  // past the limit goes back to zero; the top bit drop also wraps at 2^TICK_WIDTH
  assign tick_count_next =
    (pwsc_pkg::CMP_W'(tick_inc) > pwsc_pkg::CMP_W'(wrap_limit)) ?
    '0 : tick_inc[pwsc_pkg::TICK_WIDTH-1:0];

  assign width_abs = (tick_count >= rise_tick) ? tick_count - rise_tick
                                               : rise_tick - tick_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      rise_tick      <= '0;
      measured_width <= '0;
    end else if (accept) begin
      if (req_type == pwsc_pkg::REQ_TICK) begin
        tick_count <= tick_count_next;
      end else if (pin_level) begin
        rise_tick <= tick_count;
      end else if (rise_tick != '0) begin
        measured_width <= width_abs;
      end
    end
  end

endmodule

@@ sv/pwsc_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pwsc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [2*pwsc_pkg::REG_W-1:0]      dividend,
  input  logic [pwsc_pkg::REG_W-1:0]        divisor,
  output logic [pwsc_pkg::REG_W-1:0]        quotient,
  output pwsc_pkg::div_stat_t               stat
);

  logic [pwsc_pkg::REG_W-1:0] rem;
  logic [pwsc_pkg::REG_W-1:0] dq;      // low dividend bits shift out, quotient bits shift in
  logic [pwsc_pkg::CNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [pwsc_pkg::REG_W:0]   trial;
  logic [pwsc_pkg::REG_W:0]   diff;
  logic                       qbit;

  // high half is below the divisor since the quotient fits REG_W bits
  assign trial = {rem, dq[pwsc_pkg::REG_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = !diff[pwsc_pkg::REG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= pwsc_pkg::CNT_W'(pwsc_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == pwsc_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*pwsc_pkg::REG_W-1:pwsc_pkg::REG_W];
      dq  <= dividend[pwsc_pkg::REG_W-1:0];
    end else if (busy) begin
      rem <= qbit ? diff[pwsc_pkg::REG_W-1:0] : trial[pwsc_pkg::REG_W-1:0];
      dq  <= {dq[pwsc_pkg::REG_W-2:0], qbit};
    end
  end

  assign quotient  = dq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ sv/pulse_width_to_servo_compare_core.sv @@
// Top level: pulse width capture and linear map to a servo compare value.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tuser[0] req_type, s_tdata[0] pin_level
// m_*       out  m_tvalid/m_tready   m_tdata[15:0] compare_value, [31:16] pulse_ticks
// APB       in   psel&penable&pwrite registers at byte address 4*index
//
// Sequence per request: the accept edge updates the measurement, then PREP
// registers the clamped magnitudes, START loads the product into the divider,
// DIV waits for the divider's done flag and DONE loads the output register.
// Only an idle sequencer accepts; the output register holds a result while the
// next request is worked, and a full output register holds the sequencer in DONE.
// rst is synchronous and clears the counters, the sequencer and the output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pulse_width_to_servo_compare_core (
  input  logic                              clk,
  input  logic                              rst,
  // request in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] pin_level, [7:1] zero
  input  logic [0:0]                        s_tuser,   // [0] req_type
  // result out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,   // [15:0] compare_value, [31:16] pulse_ticks
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pwsc_pkg::ADDR_W-1:0]       paddr,
  input  logic [pwsc_pkg::DATA_W-1:0]       pwdata,
  output logic [pwsc_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int W = pwsc_pkg::REG_W;

  pwsc_pkg::cfg_t                      cfg;
  pwsc_pkg::state_t                    state;
  pwsc_pkg::state_t                    state_next;
  pwsc_pkg::div_stat_t                 div_stat;

  logic                                accept;
  logic                                div_start;
  logic                                out_load;

  logic [pwsc_pkg::TICK_WIDTH-1:0]     measured_width;

  // clamp and sign/magnitude split
  logic [W-1:0]                        x_clamp;
  logic [W:0]                          a_s;
  logic [W:0]                          d_s;
  logic [W:0]                          s_s;
  logic [W:0]                          a_n;
  logic [W:0]                          d_n;
  logic [W:0]                          s_n;
  logic [W-1:0]                        a_mag;
  logic [W-1:0]                        d_mag;
  logic [W-1:0]                        s_mag;

  logic [W-1:0]                        a_mag_q;
  logic [W-1:0]                        d_mag_q;
  logic [W-1:0]                        s_mag_q;
  logic                                neg_q;
  logic                                zero_q;

  logic [2*W-1:0]                      product;
  logic [W-1:0]                        quotient;
  logic [W-1:0]                        q_signed;
  logic [W-1:0]                        compare_value;

  assign accept = s_tvalid && s_tready;

  pwsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pwsc_meas u_meas (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .req_type       (s_tuser[0]),
    .pin_level      (s_tdata[0]),
    .wrap_limit     (cfg.wrap_limit),
    .measured_width (measured_width)
  );

  // Clamp: above in_high wins first, then below in_low. With inverted
  // bounds this leaves either in_high or in_low, never a value between.
  always_comb begin
    if (pwsc_pkg::CMP_W'(measured_width) > pwsc_pkg::CMP_W'(cfg.in_high)) begin
      x_clamp = cfg.in_high;
    end else if (pwsc_pkg::CMP_W'(measured_width) < pwsc_pkg::CMP_W'(cfg.in_low)) begin
      x_clamp = cfg.in_low;
    end else begin
      x_clamp = W'(measured_width);
    end
  end

  assign a_s   = {1'b0, x_clamp}      - {1'b0, cfg.in_low};
  assign d_s   = {1'b0, cfg.out_high} - {1'b0, cfg.out_low};
  assign s_s   = {1'b0, cfg.in_high}  - {1'b0, cfg.in_low};
  assign a_n   = -a_s;
  assign d_n   = -d_s;
  assign s_n   = -s_s;
  assign a_mag = a_s[W] ? a_n[W-1:0] : a_s[W-1:0];
  assign d_mag = d_s[W] ? d_n[W-1:0] : d_s[W-1:0];
  assign s_mag = s_s[W] ? s_n[W-1:0] : s_s[W-1:0];

  always_ff @(posedge clk) begin
    if (state == pwsc_pkg::ST_PREP) begin
      a_mag_q <= a_mag;
      d_mag_q <= d_mag;
      s_mag_q <= s_mag;
      neg_q   <= a_s[W] ^ d_s[W] ^ s_s[W];
      zero_q  <= (s_s == '0);
    end
  end

  // single 16x16 product, registered inside the divider on load
  assign product = a_mag_q * d_mag_q;

  pwsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (s_mag_q),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // truncation toward zero: divide magnitudes, then apply the sign
  assign q_signed      = neg_q ? -quotient : quotient;
  assign compare_value = zero_q ? cfg.out_low : q_signed + cfg.out_low;

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      pwsc_pkg::ST_IDLE:  if (accept) state_next = pwsc_pkg::ST_PREP;
      pwsc_pkg::ST_PREP:  state_next = pwsc_pkg::ST_START;
      pwsc_pkg::ST_START: state_next = pwsc_pkg::ST_DIV;
      pwsc_pkg::ST_DIV:   if (div_stat.done) state_next = pwsc_pkg::ST_DONE;
      pwsc_pkg::ST_DONE:  if (!m_tvalid || m_tready) state_next = pwsc_pkg::ST_IDLE;
      default:            state_next = pwsc_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      pwsc_pkg::ST_IDLE:  s_tready  = 1'b1;
      pwsc_pkg::ST_START: div_start = 1'b1;
      pwsc_pkg::ST_DONE:  out_load  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {W'(measured_width), compare_value};
    end
  end

  `ASSERT_AT(a_accept_to_prep, clk, rst, accept |=> state == pwsc_pkg::ST_PREP)
  `ASSERT_NEVER(a_div_done_out_of_seq, clk, rst, div_stat.done && state != pwsc_pkg::ST_DIV)
  `ASSERT_AT(a_div_running, clk, rst, state == pwsc_pkg::ST_DIV |-> div_stat.busy || div_stat.done)

endmodule

@@ dv/pulse_width_to_servo_compare_core_checker.sv @@
// Checker: shadow of the servo compare core; predicts each result and compares it.
`timescale 1ns / 1ps
module pulse_width_to_servo_compare_core_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [0] pin_level, [7:1] zero
  input  logic [0:0]                    s_tuser,   // [0] req_type
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [31:0]                   m_tdata,   // [15:0] compare_value, [31:16] pulse_ticks
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pwsc_pkg::DATA_W-1:0]   pwdata,
  input  logic [pwsc_pkg::DATA_W-1:0]   prdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct packed {
    logic [pwsc_pkg::REG_W-1:0] pulse_ticks;
    logic [pwsc_pkg::REG_W-1:0] compare_value;
  } servo_result_t;

  pwsc_pkg::cfg_t                  cfg_shadow;
  logic [pwsc_pkg::TICK_WIDTH-1:0] tick_count;
  logic [pwsc_pkg::TICK_WIDTH-1:0] rise_tick;
  logic [pwsc_pkg::TICK_WIDTH-1:0] pulse_width;
  servo_result_t                   awaited_q[$];
  int                              error_tally = 0;

  // clamp, then signed linear map; division truncates toward zero
  function automatic logic [pwsc_pkg::REG_W-1:0] map_to_compare(
    input logic [pwsc_pkg::TICK_WIDTH-1:0] width);
    longint x, lo, hi, olo, ohi, span, scaled;
    x    = longint'(width);
    lo   = longint'(cfg_shadow.in_low);
    hi   = longint'(cfg_shadow.in_high);
    olo  = longint'(cfg_shadow.out_low);
    ohi  = longint'(cfg_shadow.out_high);
    span = hi - lo;
    if (x > hi)
      x = hi;
    else if (x < lo)
      x = lo;
    if (span == 0)
      return cfg_shadow.out_low;
    scaled = (x - lo) * (ohi - olo) / span + olo;
    return scaled[pwsc_pkg::REG_W-1:0];
  endfunction

  // apply one request to the shadow state, return the result it produces
  function automatic servo_result_t measure_request(input logic kind, input logic level);
    logic [pwsc_pkg::TICK_WIDTH:0] next_tick;
    int                            delta;
    servo_result_t                 res;
    if (kind == pwsc_pkg::REQ_TICK) begin
      next_tick = {1'b0, tick_count} + 1'b1;
      if (next_tick > {1'b0, cfg_shadow.wrap_limit})
        next_tick = '0;
      tick_count = next_tick[pwsc_pkg::TICK_WIDTH-1:0];
    end else if (level) begin
      rise_tick = tick_count;
    end else if (rise_tick != '0) begin
      delta = int'(tick_count) - int'(rise_tick);
      if (delta < 0)
        delta = -delta;
      pulse_width = delta[pwsc_pkg::TICK_WIDTH-1:0];
    end
    res.compare_value = map_to_compare(pulse_width);
    res.pulse_ticks   = pwsc_pkg::REG_W'(pulse_width);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    servo_result_t                got;
    servo_result_t                want;
    logic [pwsc_pkg::REG_W-1:0]   reg_val;
    logic                         mapped;
    logic [2:0]                   idx;
    idx = paddr[pwsc_pkg::ADDR_W-1:2];
    if (rst) begin
      cfg_shadow.wrap_limit = 16'd60000;
      cfg_shadow.in_low     = 16'd50;
      cfg_shadow.in_high    = 16'd90;
      cfg_shadow.out_low    = 16'd1000;
      cfg_shadow.out_high   = 16'd5000;
      tick_count  = '0;
      rise_tick   = '0;
      pulse_width = '0;
      awaited_q.delete();
    end else begin
      if (psel && penable && pready && pwrite) begin
        case (idx)
          pwsc_pkg::REG_WRAP_LIMIT: cfg_shadow.wrap_limit = pwdata[pwsc_pkg::REG_W-1:0];
          pwsc_pkg::REG_IN_LOW:     cfg_shadow.in_low     = pwdata[pwsc_pkg::REG_W-1:0];
          pwsc_pkg::REG_IN_HIGH:    cfg_shadow.in_high    = pwdata[pwsc_pkg::REG_W-1:0];
          pwsc_pkg::REG_OUT_LOW:    cfg_shadow.out_low    = pwdata[pwsc_pkg::REG_W-1:0];
          pwsc_pkg::REG_OUT_HIGH:   cfg_shadow.out_high   = pwdata[pwsc_pkg::REG_W-1:0];
          default: ;
        endcase
      end else if (psel && penable && pready) begin
        mapped = 1'b1;
        case (idx)
          pwsc_pkg::REG_WRAP_LIMIT: reg_val = cfg_shadow.wrap_limit;
          pwsc_pkg::REG_IN_LOW:     reg_val = cfg_shadow.in_low;
          pwsc_pkg::REG_IN_HIGH:    reg_val = cfg_shadow.in_high;
          pwsc_pkg::REG_OUT_LOW:    reg_val = cfg_shadow.out_low;
          pwsc_pkg::REG_OUT_HIGH:   reg_val = cfg_shadow.out_high;
          default: begin
            reg_val = '0;
            mapped  = 1'b0;
          end
        endcase
        if (mapped && prdata !== pwsc_pkg::DATA_W'(reg_val)) begin
          $display("%0t: register %0d readback expected %0d actual %0d",
                   $time, idx, reg_val, prdata);
          error_tally++;
        end
      end

      // retire before predicting: a result never belongs to a same-edge request
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %0d/%0d",
                   $time, got.compare_value, got.pulse_ticks);
          error_tally++;
        end else begin
          want = awaited_q.pop_front();
          if (got.compare_value !== want.compare_value) begin
            $display("%0t: compare_value expected %0d actual %0d",
                     $time, want.compare_value, got.compare_value);
            error_tally++;
          end
          if (got.pulse_ticks !== want.pulse_ticks) begin
            $display("%0t: pulse_ticks expected %0d actual %0d",
                     $time, want.pulse_ticks, got.pulse_ticks);
            error_tally++;
          end
        end
      end
      if (s_tvalid && s_tready)
        awaited_q.push_back(measure_request(s_tuser[0], s_tdata[0]));
    end
    outstanding <= awaited_q.size();
    mismatches  <= error_tally;
  end

endmodule

@@ dv/pulse_width_to_servo_compare_core_tb.sv @@
// Testbench top: request and result traffic, register setup and verdict for the servo compare core.
`timescale 1ns / 1ps
module pulse_width_to_servo_compare_core_tb;

  // no register behind this index; writes must be dropped
  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int REQS_PER_PHASE = 90;
  localparam int SINK_HOLD      = 300;   // long receiver hold-off, in cycles

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;   // [0] pin_level, [7:1] zero
  logic [0:0]                    s_tuser = '0;   // [0] req_type
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [31:0]                   m_tdata;        // [15:0] compare_value, [31:16] pulse_ticks
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pwsc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [pwsc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [pwsc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  int fail_count;
  int outstanding;      // requests accepted whose result has not come back
  int cycle_count = 0;
  int sender_calm = 0;  // requests left in the current no-gap stretch

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pulse_width_to_servo_compare_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pulse_width_to_servo_compare_core_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(fail_count), .outstanding(outstanding)
  );

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pulse_width_to_servo_compare_core regression: fail");
      $finish;
    end
  end

  // Offer one request. Called at a falling edge, returns at the falling edge
  // after acceptance with s_tvalid still high, so a zero gap keeps the
  // stream going without a drop in valid.
  task automatic offer(input logic kind, input logic level);
    int gap;
    if (sender_calm > 0) begin
      sender_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 19) == 0)
        sender_calm = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {7'b0, level};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // timer ticks; the level bit is don't-care here, so it is randomized
  task automatic ticks(input int n);
    repeat (n) offer(pwsc_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [15:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    // upper data bits are junk; the registers are only 16 bits wide
    pwdata  = {16'($urandom()), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic setup(input logic [15:0] wrap, input logic [15:0] lo, input logic [15:0] hi,
                       input logic [15:0] olo, input logic [15:0] ohi);
    apb_access(1'b1, pwsc_pkg::REG_WRAP_LIMIT, wrap);
    apb_access(1'b1, pwsc_pkg::REG_IN_LOW, lo);
    apb_access(1'b1, pwsc_pkg::REG_IN_HIGH, hi);
    apb_access(1'b1, pwsc_pkg::REG_OUT_LOW, olo);
    apb_access(1'b1, pwsc_pkg::REG_OUT_HIGH, ohi);
    // readback; the checker compares prdata against its shadow
    apb_access(1'b0, pwsc_pkg::REG_WRAP_LIMIT, '0);
    apb_access(1'b0, pwsc_pkg::REG_IN_LOW, '0);
    apb_access(1'b0, pwsc_pkg::REG_IN_HIGH, '0);
    apb_access(1'b0, pwsc_pkg::REG_OUT_LOW, '0);
    apb_access(1'b0, pwsc_pkg::REG_OUT_HIGH, '0);
  endtask

  function automatic logic [15:0] any_out();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Result side: random backpressure per result, occasional runs with
  // tready held high, and two long hold-offs so the core backs up and
  // drops s_tready while the sender keeps offering.
  initial begin : sink
    int gap;
    int calm;
    int taken;
    calm  = 0;
    taken = 0;
    @(negedge clk);
    forever begin
      if (taken == 150 || taken == 450) begin
        gap = SINK_HOLD;
      end else if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 19) == 0)
          calm = $urandom_range(8, 40);
      end
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int          phase;
    int          sent;
    int          len;
    logic [15:0] wrap, lo, hi;

    repeat (7) @(negedge clk);
    rst = 1'b0;

    // --- directed, reset register values (60000 / 50..90 / 1000..5000)
    offer(pwsc_pkg::REQ_PIN, 1'b0);   // fall with no rise recorded: width stays 0
    offer(pwsc_pkg::REQ_PIN, 1'b1);   // rise while the counter is 0
    ticks(2);
    offer(pwsc_pkg::REQ_PIN, 1'b0);   // rise tick is zero: width unchanged
    offer(pwsc_pkg::REQ_PIN, 1'b1);   // rise at tick 2
    ticks(3);
    offer(pwsc_pkg::REQ_PIN, 1'b0);   // width 3, clamped up to in_low
    settle();

    // --- small wrap, falling map across the full output range; fall after wrap
    apb_access(1'b1, REG_UNMAPPED, 16'h1234);   // must not land anywhere
    setup(16'd5, 16'd1, 16'd4, 16'hFFFF, 16'h0000);
    ticks(5);                         // 5 wraps to 0, then up to 4
    offer(pwsc_pkg::REQ_PIN, 1'b1);   // rise at 4
    ticks(3);                         // 5, 0, 1
    offer(pwsc_pkg::REQ_PIN, 1'b0);   // signed distance made absolute: 3
    settle();

    // --- equal input bounds: always out_low
    setup(16'd65535, 16'd3, 16'd3, 16'd777, 16'd9999);
    offer(pwsc_pkg::REQ_PIN, 1'b1);
    ticks(2);
    offer(pwsc_pkg::REQ_PIN, 1'b0);
    settle();

    // --- inverted input bounds: above in_high gives out_high, else out_low
    setup(16'd65535, 16'd10, 16'd2, 16'd100, 16'd200);
    offer(pwsc_pkg::REQ_PIN, 1'b1);
    ticks(4);
    offer(pwsc_pkg::REQ_PIN, 1'b0);
    offer(pwsc_pkg::REQ_PIN, 1'b1);
    ticks(1);
    offer(pwsc_pkg::REQ_PIN, 1'b0);
    settle();

    // --- zero wrap limit: counter pinned at 0, falls never measure
    setup(16'd0, 16'd0, 16'd65535, 16'd0, 16'd65535);
    ticks(2);
    offer(pwsc_pkg::REQ_PIN, 1'b1);
    offer(pwsc_pkg::REQ_PIN, 1'b0);
    settle();

    // --- random phases: new settings each time, mostly whole pulses
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       wrap = 16'd1;
        1:       wrap = 16'($urandom_range(2, 40));
        2:       wrap = 16'hFFFF;
        default: wrap = 16'($urandom());
      endcase
      lo = 16'($urandom_range(0, 20));
      hi = lo + 16'($urandom_range(0, 20));
      case ($urandom_range(0, 7))
        0: hi = lo;                            // equal bounds
        1: {lo, hi} = {hi + 16'd1, lo};        // inverted bounds
        default: ;
      endcase
      if (phase == 0 || $urandom_range(0, 9) == 0) begin
        lo = 16'($urandom());
        hi = 16'($urandom());
      end
      setup(wrap, lo, hi, any_out(), any_out());

      sent = 0;
      while (sent < REQS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) begin
          // stray request: lone tick, lone rise or lone fall
          offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 24);
          offer(pwsc_pkg::REQ_PIN, 1'b1);
          ticks(len);
          offer(pwsc_pkg::REQ_PIN, 1'b0);
          sent += len + 2;
        end
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("pulse_width_to_servo_compare_core regression: pass");
    else
      $display("pulse_width_to_servo_compare_core regression: fail");
    $finish;
  end

endmodule
